// ===== design/scp_pkg.sv =====
// Shared constants for the segment closest-points pipeline.
package scp_pkg;

    localparam int FIELD_W    = 32;
    localparam int IN_FIELDS  = 12;
    localparam int OUT_FIELDS = 6;
    localparam int IN_W       = FIELD_W * IN_FIELDS;
    localparam int OUT_DW     = FIELD_W * OUT_FIELDS;
    localparam int OUT_W      = 32;
    localparam int SFRAC      = 32;
    localparam int THR_W      = 32;
    localparam int MUL_LAT    = 2;
    localparam int DIV_LAT    = SFRAC + 1;

    localparam logic [THR_W-1:0] THR_RESET = 32'd4295;

endpackage

// ===== design/scp_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
module scp_mul #(
    parameter int WA = 34,
    parameter int WB = 34
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [WA-1:0]        a,
    input  logic signed [WB-1:0]        b,
    output logic signed [WA+WB-1:0]     p
);

    localparam int HA = WA / 2;
    localparam int HB = WB / 2;
    localparam int WP = WA + WB;

    logic signed [WA-HA-1:0]          ah;
    logic signed [HA:0]               al;
    logic signed [WB-HB-1:0]          bh;
    logic signed [HB:0]               bl;
    logic signed [WA-HA+WB-HB-1:0]    hh_reg;
    logic signed [WA-HA+HB:0]         hl_reg;
    logic signed [HA+WB-HB:0]         lh_reg;
    logic signed [HA+HB+1:0]          ll_reg;
    logic signed [WP-1:0]             sum_next;

    assign ah = a[WA-1:HA];
    assign al = $signed({1'b0, a[HA-1:0]});
    assign bh = b[WB-1:HB];
    assign bl = $signed({1'b0, b[HB-1:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= ah * bh;
            hl_reg <= ah * bl;
            lh_reg <= al * bh;
            ll_reg <= al * bl;
        end
    end

    always_comb
    begin
        sum_next = (WP'(hh_reg) <<< (HA + HB)) + (WP'(hl_reg) <<< HA)
                 + (WP'(lh_reg) <<< HB) + WP'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p <= sum_next;
        end
    end

endmodule

// ===== design/scp_div.sv =====
// Pipelined restoring divider giving a quotient clamped to [0, 1] in unsigned Q1.32.
module scp_div
    import scp_pkg::*;
#(
    parameter int W = 70
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic [SFRAC:0]      quo
);

    logic [W-1:0]       rem_reg  [SFRAC+1];
    logic [W-1:0]       den_reg  [SFRAC+1];
    logic [SFRAC-1:0]   q_reg    [SFRAC+1];
    logic               zero_reg [SFRAC+1];
    logic               one_reg  [SFRAC+1];
    logic [W:0]         r2       [SFRAC];
    logic               ge       [SFRAC];
    logic [W-1:0]       rem_next [SFRAC];

    always_comb
    begin
        for (int i = 0; i < SFRAC; i++)
        begin
            r2[i]       = {rem_reg[i], 1'b0};
            ge[i]       = r2[i] >= {1'b0, den_reg[i]};
            rem_next[i] = ge[i] ? W'(r2[i] - {1'b0, den_reg[i]}) : W'(r2[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            zero_reg[0] <= num <= 0;
            one_reg[0]  <= (num > 0) && (num >= den);
            for (int i = 0; i < SFRAC; i++)
            begin
                rem_reg[i+1]  <= rem_next[i];
                den_reg[i+1]  <= den_reg[i];
                q_reg[i+1]    <= {q_reg[i][SFRAC-2:0], ge[i]};
                zero_reg[i+1] <= zero_reg[i];
                one_reg[i+1]  <= one_reg[i];
            end
        end
    end

    assign quo = one_reg[SFRAC]  ? {1'b1, {SFRAC{1'b0}}} :
                 zero_reg[SFRAC] ? '0 : {1'b0, q_reg[SFRAC]};

endmodule

// ===== design/segment_closest_points.sv =====
// Top level: closest points between two 3D segments, fully pipelined.
// One segment pair enters per clock while the output is not stalled, and its two closest
// points appear on the output in the order the pairs were accepted; a stall on the output
// side freezes the whole pipeline. The depth is set by two 33-stage restoring dividers in series (segment
// parameter s, then t) plus the split multipliers that feed them. The threshold register
// is read live, so write it only while no item is in flight.
module segment_closest_points
    import scp_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
    // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z
    output logic [OUT_DW-1:0]   m_tdata,
    input  logic                cfg_wen,
    input  logic [THR_W-1:0]    cfg_wdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int D   = CW + 1;
    localparam int PD  = 2 * D;
    localparam int DOT = PD + 2;
    localparam int WN  = 2 * DOT + 1;
    localparam int SW  = SFRAC + 2;
    localparam int TNW = DOT + SFRAC + 3;
    localparam int PLW = D + SW;
    localparam int PX  = (PLW + 1 > OUT_W + SFRAC) ? PLW + 1 : OUT_W + SFRAC;

    localparam int ST_DOT = MUL_LAT + 1;
    localparam int ST_DEN = ST_DOT + MUL_LAT + 1;
    localparam int ST_SEL = ST_DEN + DIV_LAT + 1;
    localparam int ST_TN  = ST_SEL + MUL_LAT + 1;
    localparam int ST_FIN = ST_TN + DIV_LAT + 1;
    localparam int ST_OUT = ST_FIN + MUL_LAT + 1;
    localparam int NST    = ST_OUT + 1;

    typedef struct packed {
        logic [2:0][CW-1:0]         a1;
        logic [2:0][CW-1:0]         b1;
        logic [2:0][D-1:0]          da;
        logic [2:0][D-1:0]          db;
        logic [2:0][D-1:0]          rv;
        logic                       ad;
        logic                       ed;
        logic [DOT-1:0]             a;
        logic [DOT-1:0]             b;
        logic [DOT-1:0]             e;
        logic [DOT-1:0]             f;
        logic [DOT:0]               negc;
        logic [DOT:0]               bmc;
        logic [WN-1:0]              den;
        logic [WN-1:0]              num;
        logic                       dpos;
        logic [SFRAC:0]             s_use;
        logic [SFRAC:0]             s_a;
        logic [SFRAC:0]             s_b;
        logic [TNW-1:0]             tn;
        logic                       tneg;
        logic                       tgt;
        logic [SFRAC:0]             s_fin;
        logic [SFRAC:0]             t_fin;
        logic [OUT_FIELDS-1:0][OUT_W-1:0] res;
    } car_t;

    car_t               car_reg  [NST];
    car_t               car_next [NST];
    logic [NST-1:0]     vld_reg;
    logic [THR_W-1:0]   thr_reg;
    logic               adv;

    logic signed [PD-1:0]   m_aa [3];
    logic signed [PD-1:0]   m_ee [3];
    logic signed [PD-1:0]   m_ef [3];
    logic signed [PD-1:0]   m_ac [3];
    logic signed [PD-1:0]   m_ab [3];
    logic signed [2*DOT-1:0] p_ae, p_bb, p_bf, p_ce;
    logic signed [DOT+SW-1:0] p_bs;
    logic signed [PLW-1:0]  p_pl [OUT_FIELDS];
    logic [SFRAC:0]         q_gen, q_sa, q_sb, q_t;
    logic signed [TNW-1:0]  tdiv_num, tdiv_den;

    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = car_reg[NST-1].res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wen)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            car_reg <= car_next;
        end
    end

    // dot-product terms
    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        scp_mul #(.WA(D), .WB(D)) u_aa (.clk, .en(adv),
            .a($signed(car_reg[0].da[i])), .b($signed(car_reg[0].da[i])), .p(m_aa[i]));
        scp_mul #(.WA(D), .WB(D)) u_ee (.clk, .en(adv),
            .a($signed(car_reg[0].db[i])), .b($signed(car_reg[0].db[i])), .p(m_ee[i]));
        scp_mul #(.WA(D), .WB(D)) u_ef (.clk, .en(adv),
            .a($signed(car_reg[0].db[i])), .b($signed(car_reg[0].rv[i])), .p(m_ef[i]));
        scp_mul #(.WA(D), .WB(D)) u_ac (.clk, .en(adv),
            .a($signed(car_reg[0].da[i])), .b($signed(car_reg[0].rv[i])), .p(m_ac[i]));
        scp_mul #(.WA(D), .WB(D)) u_ab (.clk, .en(adv),
            .a($signed(car_reg[0].da[i])), .b($signed(car_reg[0].db[i])), .p(m_ab[i]));
    end

    scp_mul #(.WA(DOT), .WB(DOT)) u_ae (.clk, .en(adv),
        .a($signed(car_reg[ST_DOT].a)), .b($signed(car_reg[ST_DOT].e)), .p(p_ae));
    scp_mul #(.WA(DOT), .WB(DOT)) u_bb (.clk, .en(adv),
        .a($signed(car_reg[ST_DOT].b)), .b($signed(car_reg[ST_DOT].b)), .p(p_bb));
    scp_mul #(.WA(DOT), .WB(DOT)) u_bf (.clk, .en(adv),
        .a($signed(car_reg[ST_DOT].b)), .b($signed(car_reg[ST_DOT].f)), .p(p_bf));
    scp_mul #(.WA(DOT), .WB(DOT)) u_ce (.clk, .en(adv),
        .a(-$signed(car_reg[ST_DOT].negc[DOT-1:0])), .b($signed(car_reg[ST_DOT].e)),
        .p(p_ce));

    scp_div #(.W(WN)) u_div_gen (.clk, .en(adv),
        .num($signed(car_reg[ST_DEN].num)), .den($signed(car_reg[ST_DEN].den)), .quo(q_gen));
    scp_div #(.W(DOT + 1)) u_div_sa (.clk, .en(adv),
        .num($signed(car_reg[ST_DEN].negc)),
        .den((DOT + 1)'($signed(car_reg[ST_DEN].a))), .quo(q_sa));
    scp_div #(.W(DOT + 1)) u_div_sb (.clk, .en(adv),
        .num($signed(car_reg[ST_DEN].bmc)),
        .den((DOT + 1)'($signed(car_reg[ST_DEN].a))), .quo(q_sb));

    scp_mul #(.WA(DOT), .WB(SW)) u_bs (.clk, .en(adv),
        .a($signed(car_reg[ST_SEL].b)), .b($signed({1'b0, car_reg[ST_SEL].s_use})),
        .p(p_bs));

    assign tdiv_den = TNW'($signed(car_reg[ST_TN].e)) <<< SFRAC;
    assign tdiv_num = car_reg[ST_TN].ad ? (TNW'($signed(car_reg[ST_TN].f)) <<< SFRAC)
                                        : $signed(car_reg[ST_TN].tn);

    scp_div #(.W(TNW)) u_div_t (.clk, .en(adv),
        .num(tdiv_num), .den(tdiv_den), .quo(q_t));

    for (genvar i = 0; i < 3; i++)
    begin : g_place
        scp_mul #(.WA(D), .WB(SW)) u_pa (.clk, .en(adv),
            .a($signed(car_reg[ST_FIN].da[i])), .b($signed({1'b0, car_reg[ST_FIN].s_fin})),
            .p(p_pl[i]));
        scp_mul #(.WA(D), .WB(SW)) u_pb (.clk, .en(adv),
            .a($signed(car_reg[ST_FIN].db[i])), .b($signed({1'b0, car_reg[ST_FIN].t_fin})),
            .p(p_pl[3+i]));
    end

    always_comb
    begin
        logic signed [CW-1:0]   as_s, ae_s, bs_s, be_s;
        logic signed [DOT-1:0]  a_s, e_s, f_s, c_s, b_s;
        logic signed [TNW-1:0]  tn_s, td_s;
        logic signed [PX-1:0]   rnd;
        logic signed [CW-1:0]   st_s;

        car_next[0] = '0;
        for (int i = 0; i < 3; i++)
        begin
            as_s = s_tdata[FIELD_W*i +: CW];
            ae_s = s_tdata[FIELD_W*(3+i) +: CW];
            bs_s = s_tdata[FIELD_W*(6+i) +: CW];
            be_s = s_tdata[FIELD_W*(9+i) +: CW];
            car_next[0].a1[i] = as_s;
            car_next[0].b1[i] = bs_s;
            car_next[0].da[i] = D'(ae_s) - D'(as_s);
            car_next[0].db[i] = D'(be_s) - D'(bs_s);
            car_next[0].rv[i] = D'(as_s) - D'(bs_s);
        end

        for (int k = 1; k < NST; k++)
        begin
            car_next[k] = car_reg[k-1];
        end

        // dot products and degenerate flags
        a_s = DOT'(m_aa[0]) + DOT'(m_aa[1]) + DOT'(m_aa[2]);
        e_s = DOT'(m_ee[0]) + DOT'(m_ee[1]) + DOT'(m_ee[2]);
        f_s = DOT'(m_ef[0]) + DOT'(m_ef[1]) + DOT'(m_ef[2]);
        c_s = DOT'(m_ac[0]) + DOT'(m_ac[1]) + DOT'(m_ac[2]);
        b_s = DOT'(m_ab[0]) + DOT'(m_ab[1]) + DOT'(m_ab[2]);
        car_next[ST_DOT].a    = a_s;
        car_next[ST_DOT].e    = e_s;
        car_next[ST_DOT].f    = f_s;
        car_next[ST_DOT].b    = b_s;
        car_next[ST_DOT].negc = -(DOT + 1)'(c_s);
        car_next[ST_DOT].bmc  = (DOT + 1)'(b_s) - (DOT + 1)'(c_s);
        car_next[ST_DOT].ad   = a_s <= $signed({1'b0, thr_reg});
        car_next[ST_DOT].ed   = e_s <= $signed({1'b0, thr_reg});

        car_next[ST_DEN].den  = WN'(p_ae) - WN'(p_bb);
        car_next[ST_DEN].num  = WN'(p_bf) - WN'(p_ce);
        car_next[ST_DEN].dpos = (WN'(p_ae) - WN'(p_bb)) > 0;

        car_next[ST_SEL].s_use = car_reg[ST_SEL-1].dpos ? q_gen : '0;
        car_next[ST_SEL].s_a   = q_sa;
        car_next[ST_SEL].s_b   = q_sb;

        tn_s = TNW'(p_bs) + (TNW'($signed(car_reg[ST_TN-1].f)) <<< SFRAC);
        td_s = TNW'($signed(car_reg[ST_TN-1].e)) <<< SFRAC;
        car_next[ST_TN].tn   = tn_s;
        car_next[ST_TN].tneg = tn_s < 0;
        car_next[ST_TN].tgt  = tn_s > td_s;

        // pick s and t by case
        priority if (car_reg[ST_FIN-1].ad && car_reg[ST_FIN-1].ed)
        begin
            car_next[ST_FIN].s_fin = '0;
            car_next[ST_FIN].t_fin = '0;
        end
        else if (car_reg[ST_FIN-1].ad)
        begin
            car_next[ST_FIN].s_fin = '0;
            car_next[ST_FIN].t_fin = q_t;
        end
        else if (car_reg[ST_FIN-1].ed || car_reg[ST_FIN-1].tneg)
        begin
            car_next[ST_FIN].s_fin = car_reg[ST_FIN-1].s_a;
            car_next[ST_FIN].t_fin = '0;
        end
        else if (car_reg[ST_FIN-1].tgt)
        begin
            car_next[ST_FIN].s_fin = car_reg[ST_FIN-1].s_b;
            car_next[ST_FIN].t_fin = {1'b1, {SFRAC{1'b0}}};
        end
        else
        begin
            car_next[ST_FIN].s_fin = car_reg[ST_FIN-1].s_use;
            car_next[ST_FIN].t_fin = q_t;
        end

        // round half up and add start point
        for (int i = 0; i < OUT_FIELDS; i++)
        begin
            rnd  = PX'(p_pl[i]) + (PX'(1) <<< (SFRAC - 1));
            st_s = (i < 3) ? $signed(car_reg[ST_OUT-1].a1[i % 3])
                           : $signed(car_reg[ST_OUT-1].b1[i % 3]);
            car_next[ST_OUT].res[i] = OUT_W'(st_s) + rnd[SFRAC+OUT_W-1:SFRAC];
        end
    end

endmodule

// ===== design/scp_chk.sv =====
// Port-level checker for the segment closest-points block, with its bind.
module scp_chk
    import scp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_DW-1:0]    m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_stall_propagates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline frozen");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind segment_closest_points scp_chk u_scp_chk (.*);

// ===== dv/segment_closest_points_test.sv =====
// Testbench for segment_closest_points: random and directed segment pairs checked by a scoreboard.
module segment_closest_points_test;
    import scp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] wide_t;

    class closest_point_board;
        logic [THR_W-1:0]  threshold;
        logic [OUT_DW-1:0] pending_points[$];
        int                mismatches;

        function new();
            threshold  = THR_RESET;
            mismatches = 0;
        endfunction

        function logic [32:0] clamp_ratio(wide_t num, wide_t den);
            wide_t q;
            if (num <= 0)
                return 33'd0;
            if (num >= den)
                return 33'h1_0000_0000;
            q = (num <<< 32) / den;
            return {1'b0, q[31:0]};
        endfunction

        function logic [31:0] place(wide_t start, wide_t delta, logic [32:0] frac);
            wide_t p;
            p = delta * wide_t'({1'b0, frac}) + (wide_t'(1) <<< 31);
            return start[31:0] + p[63:32];
        endfunction

        function void note_pair(logic [IN_W-1:0] pair);
            wide_t       a1[3], b1[3], da[3], db[3], rv[3];
            wide_t       a, e, f, c, b, den, tn, td, thr;
            logic [32:0] s, t;
            logic [OUT_DW-1:0] pts;
            for (int k = 0; k < 3; k++)
            begin
                a1[k] = $signed(pair[k*32 +: 32]);
                b1[k] = $signed(pair[(6+k)*32 +: 32]);
                da[k] = wide_t'($signed(pair[(3+k)*32 +: 32])) - a1[k];
                db[k] = wide_t'($signed(pair[(9+k)*32 +: 32])) - b1[k];
                rv[k] = a1[k] - b1[k];
            end
            a   = da[0]*da[0] + da[1]*da[1] + da[2]*da[2];
            e   = db[0]*db[0] + db[1]*db[1] + db[2]*db[2];
            f   = db[0]*rv[0] + db[1]*rv[1] + db[2]*rv[2];
            c   = da[0]*rv[0] + da[1]*rv[1] + da[2]*rv[2];
            b   = da[0]*db[0] + da[1]*db[1] + da[2]*db[2];
            thr = wide_t'({1'b0, threshold});
            s   = 0;
            t   = 0;
            if (a <= thr && e <= thr)
            begin
                s = 0;
                t = 0;
            end
            else if (a <= thr)
                t = clamp_ratio(f, e);
            else if (e <= thr)
                s = clamp_ratio(-c, a);
            else
            begin
                den = a*e - b*b;
                s   = (den > 0) ? clamp_ratio(b*f - c*e, den) : 33'd0;
                tn  = b * wide_t'({1'b0, s}) + (f <<< 32);
                td  = e <<< 32;
                if (tn < 0)
                begin
                    t = 0;
                    s = clamp_ratio(-c, a);
                end
                else if (tn > td)
                begin
                    t = 33'h1_0000_0000;
                    s = clamp_ratio(b - c, a);
                end
                else
                    t = clamp_ratio(tn, td);
            end
            for (int k = 0; k < 3; k++)
            begin
                pts[k*32 +: 32]     = place(a1[k], da[k], s);
                pts[(3+k)*32 +: 32] = place(b1[k], db[k], t);
            end
            pending_points.push_back(pts);
        endfunction

        function void check_points(logic [OUT_DW-1:0] got);
            logic [OUT_DW-1:0] want;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending_points.pop_front();
            for (int k = 0; k < OUT_FIELDS; k++)
                if (want[k*32 +: 32] !== got[k*32 +: 32])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("field %0d: expected %h, got %h", k,
                                 want[k*32 +: 32], got[k*32 +: 32]);
                end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [OUT_DW-1:0] m_tdata;
    logic              cfg_wen = 0;
    logic [THR_W-1:0]  cfg_wdata = '0;

    closest_point_board board = new();
    int  cycles = 0;
    int  out_stall = 0;
    bit  burst = 0;
    bit  out_burst = 0;

    segment_closest_points dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        int n;
        if (m_tvalid && m_tready)
            board.check_points(m_tdata);
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                m_tready  <= (out_stall == 1);
            end
            else if (m_tvalid && m_tready || !m_tready)
            begin
                if ($urandom_range(0, 29) == 0)
                    out_burst <= ~out_burst;
                n = out_burst ? 0 : $urandom_range(0, 9);
                out_stall <= n;
                m_tready  <= (n == 0);
            end
        end
    end

    task automatic send_pair(logic [IN_W-1:0] pair);
        int gap;
        if ($urandom_range(0, 39) == 0)
            burst = ~burst;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= pair;
        do @(posedge clk); while (!s_tready);
        board.note_pair(pair);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (board.pending_points.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        drain();
        cfg_wen   <= 1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 0;
        board.threshold = value;
    endtask

    function automatic logic [IN_W-1:0] pack(int v[12]);
        logic [IN_W-1:0] r;
        for (int k = 0; k < 12; k++)
            r[k*32 +: 32] = v[k];
        return r;
    endfunction

    function automatic int coord(int span);
        case (span)
            0: return $urandom();
            1: return int'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
            default: return int'($urandom_range(0, 32'h7FFFFFF)) - 32'h4000000;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] random_pair();
        int v[12];
        int span, kind, off;
        span = $urandom_range(0, 2);
        kind = $urandom_range(0, 7);
        for (int k = 0; k < 12; k++)
            v[k] = coord(span);
        case (kind)
            0: for (int k = 0; k < 3; k++) v[3+k] = v[k] + $urandom_range(0, 1);
            1: for (int k = 0; k < 3; k++) v[9+k] = v[6+k] + $urandom_range(0, 1);
            2:
            begin
                off = $urandom_range(1, 3);
                for (int k = 0; k < 3; k++)
                begin
                    v[3+k] = v[k] / 2 + coord(1);
                    v[6+k] = v[k] + off * 65536;
                    v[9+k] = v[6+k] + (v[3+k] - v[k]) * ($urandom_range(0, 1) ? 1 : -1);
                end
            end
            3: for (int k = 0; k < 12; k++) v[k] = $urandom_range(0, 1) ? 32'h7FFFFFFF
                                                                          : 32'h80000000;
            default: ;
        endcase
        return pack(v);
    endfunction

    initial
    begin
        logic [THR_W-1:0] thr_set[4];
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_pair(pack('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
        send_pair(pack('{5,5,5, 5,5,5, 0,0,0, 65536,0,0}));
        send_pair(pack('{0,0,0, 65536,0,0, 3,7,9, 3,7,9}));
        send_pair(pack('{0,0,0, 65536,0,0, 0,65536,0, 65536,65536,0}));
        send_pair(pack('{0,0,0, 65536,0,0, 32768,-65536,65536, 32768,65536,65536}));
        send_pair(pack('{0,0,0, 65536,0,0, 300000,65536,0, 400000,-65536,0}));
        send_pair(pack('{0,0,0, 65536,0,0, -300000,65536,0, -200000,-65536,0}));
        send_pair(pack('{0,0,0, 65536,0,0, 0,65536,0, 0,131072,0}));
        send_pair(pack('{32'h80000000,32'h80000000,32'h80000000,
                         32'h7FFFFFFF,32'h7FFFFFFF,32'h7FFFFFFF,
                         32'h7FFFFFFF,32'h80000000,32'h7FFFFFFF,
                         32'h80000000,32'h7FFFFFFF,32'h80000000}));
        send_pair(pack('{32'h7FFFFFFF,0,0, 32'h80000000,0,0,
                         0,32'h7FFFFFFF,0, 0,32'h80000000,0}));
        send_pair(pack('{-1,-1,-1, 1,1,1, 1,-1,1, -1,1,-1}));
        send_pair(pack('{0,0,0, 65536,65536,0, 0,0,65536, 65536,65536,65536}));

        thr_set = '{32'd0, 32'hFFFFFFFF, $urandom(), THR_RESET};
        for (int p = 0; p < 4; p++)
        begin
            write_threshold(thr_set[p]);
            for (int i = 0; i < 360; i++)
            begin
                if (p == 1 && i == 180)
                    drain();
                send_pair(random_pair());
            end
        end

        drain();
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
